// ===== hw/rtl/qpv_pkg.sv =====
// Shared types and constants for the quadrature position and velocity block.
`default_nettype none
package qpv_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_EDGE_LEFT  = 2'd0;
  localparam logic [1:0] OP_EDGE_RIGHT = 2'd1;
  localparam logic [1:0] OP_VELOCITY   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_REVERSE_LEFT  = 1'b0;
  localparam logic CFG_REVERSE_RIGHT = 1'b1;

  // Microseconds per second and 2*pi/663 as a Q0.24 constant.
  localparam logic [19:0] US_PER_SEC        = 20'd1000000;
  localparam logic [17:0] RAD_PER_COUNT_Q24 = 18'd158996;

  // Largest magnitude whose product with US_PER_SEC still fits 64 bits.
  localparam logic [63:0] MAG_LIMIT = 64'd18446744073709;

  // Saturated Q16.16 speeds.
  localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SPEED_MIN = 32'h8000_0000;

  // Quotient bits produced by the divider, one per step.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_INIT,
    ST_DIV,
    ST_SCALE,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mag;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic scale;
    logic clamp;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dt_zero;
    logic is_velocity;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/qpv_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`default_nettype none
module qpv_ctrl
  import qpv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t                state;
  state_t                state_next;
  logic [DIV_CNT_W-1:0]  step_cnt;
  logic [DIV_CNT_W-1:0]  step_cnt_next;
  logic                  out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // State, divider step count and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        // Edge items and unused codes go straight to the result.
        if (!status.is_velocity) begin
          state_next = ST_DONE;
        end else begin
          cmd.mag    = 1'b1;
          state_next = status.dt_zero ? ST_CLAMP : ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init  = 1'b1;
        step_cnt_next = '0;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + DIV_CNT_W'(1);
        if (step_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qpv_lane.sv =====
// Velocity lane for one wheel: magnitude, scaling by 1e6, divide, Q16.16 and clamp.
`default_nettype none
module qpv_lane
  import qpv_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  input  wire logic                   load,
  input  wire logic [COUNT_WIDTH-1:0] diff_in,
  input  wire logic [TIME_WIDTH-1:0]  dt,
  input  wire logic                   dt_zero,
  output logic [31:0]                 speed
);

  localparam int EW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  logic [COUNT_WIDTH-1:0] diff;
  logic [COUNT_WIDTH-1:0] mag_raw;
  logic                   neg;
  logic                   sat;
  logic [63:0]            mag;
  logic [63:0]            acc;
  logic [51:0]            prod_lo;
  logic [51:0]            prod_hi;
  logic [EW-1:0]          hi_ext;
  logic [EW-1:0]          dt_ext;
  logic [TIME_WIDTH-1:0]  rem;
  logic [31:0]            quo;
  logic [TIME_WIDTH:0]    shifted;
  logic [TIME_WIDTH:0]    trial;
  logic [49:0]            scaled;
  logic [41:0]            rate;

  assign mag_raw = diff[COUNT_WIDTH-1] ? (~diff + COUNT_WIDTH'(1)) : diff;
  assign prod_lo = mag[31:0] * US_PER_SEC;
  assign prod_hi = mag[63:32] * US_PER_SEC;
  assign hi_ext  = EW'(acc[63:32]);
  assign dt_ext  = EW'(dt);
  assign shifted = {rem, quo[31]};
  assign trial   = shifted - {1'b0, dt};
  assign rate    = scaled[49:8];

  // Datapath registers; only the stored speed is architectural state.
  always_ff @(posedge clk) begin
    if (load) begin
      diff <= diff_in;
    end
    // Signed difference to sign and magnitude, with the overflow precheck.
    if (cmd.mag) begin
      neg <= diff[COUNT_WIDTH-1];
      mag <= 64'(mag_raw);
      sat <= (64'(mag_raw) > MAG_LIMIT);
    end
    // Counts times 1e6 in two 32-bit chunks.
    if (cmd.mul_lo) begin
      acc <= 64'(prod_lo);
    end
    if (cmd.mul_hi) begin
      acc <= acc + {prod_hi[31:0], 32'd0};
    end
    // A quotient of 2^32 or more saturates; otherwise the upper half seeds the remainder.
    if (cmd.div_init) begin
      if (hi_ext >= dt_ext) begin
        sat <= 1'b1;
      end
      rem <= TIME_WIDTH'(hi_ext);
      quo <= acc[31:0];
    end
    // One restoring shift-subtract step.
    if (cmd.div_step) begin
      if (!trial[TIME_WIDTH]) begin
        rem <= trial[TIME_WIDTH-1:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[TIME_WIDTH-1:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (cmd.scale) begin
      scaled <= quo * RAD_PER_COUNT_Q24;
    end
  end

  // Stored speed in Q16.16, clamped to the signed 32-bit range.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
    end else if (cmd.clamp) begin
      if (dt_zero) begin
        speed <= '0;
      end else if (sat || (!neg && rate > 42'(SPEED_MAX)) ||
                   (neg && rate > 42'(SPEED_MIN))) begin
        speed <= neg ? SPEED_MIN : SPEED_MAX;
      end else if (neg) begin
        speed <= ~rate[31:0] + 32'd1;
      end else begin
        speed <= rate[31:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/qpv_datapath.sv =====
// Datapath: wheel counters, velocity snapshots, two velocity lanes and the result register.
`default_nettype none
module qpv_datapath
  import qpv_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data,
  input  wire logic [1:0]  operation,
  input  wire logic        pin_a,
  input  wire logic        pin_b,
  input  wire logic [31:0] now_us,
  output logic [31:0]      pos_left,
  output logic [31:0]      pos_right,
  output logic [31:0]      vel_left,
  output logic [31:0]      vel_right,
  output logic             time_fault
);

  logic                   reverse_left;
  logic                   reverse_right;
  logic [COUNT_WIDTH-1:0] left_count;
  logic [COUNT_WIDTH-1:0] right_count;
  logic                   left_b_level;
  logic                   right_b_level;
  logic [COUNT_WIDTH-1:0] left_prev_count;
  logic [COUNT_WIDTH-1:0] right_prev_count;
  logic [TIME_WIDTH-1:0]  prev_time;
  logic [TIME_WIDTH-1:0]  now_ext;
  logic [TIME_WIDTH-1:0]  dt_now;
  logic [TIME_WIDTH-1:0]  dt;
  logic                   dt_zero;
  logic                   is_velocity;
  logic                   fault;
  logic                   vel_load;
  logic [COUNT_WIDTH-1:0] left_edge;
  logic [COUNT_WIDTH-1:0] right_edge;
  logic [31:0]            left_speed;
  logic [31:0]            right_speed;

  // One decoder step: move toward A versus the old B, then A versus the new B.
  function automatic logic [COUNT_WIDTH-1:0] edge_step(
    input logic [COUNT_WIDTH-1:0] count,
    input logic                   b_old,
    input logic                   a,
    input logic                   b
  );
    logic [COUNT_WIDTH-1:0] mid;
    mid = (a != b_old) ? count + COUNT_WIDTH'(1) : count - COUNT_WIDTH'(1);
    return (a == b) ? mid + COUNT_WIDTH'(1) : mid - COUNT_WIDTH'(1);
  endfunction

  // Report a speed, negated when reversed; the most negative value maps to the maximum.
  function automatic logic [31:0] reported(input logic [31:0] v, input logic rev);
    logic [31:0] r;
    if (!rev) begin
      r = v;
    end else if (v == SPEED_MIN) begin
      r = SPEED_MAX;
    end else begin
      r = ~v + 32'd1;
    end
    return r;
  endfunction

  assign left_edge  = edge_step(left_count, left_b_level, pin_a, pin_b);
  assign right_edge = edge_step(right_count, right_b_level, pin_a, pin_b);
  assign now_ext    = TIME_WIDTH'(now_us);
  assign dt_now     = now_ext - prev_time;
  assign vel_load   = cmd.accept && (operation == OP_VELOCITY);

  assign status.dt_zero     = dt_zero;
  assign status.is_velocity = is_velocity;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_left  <= 1'b1;
      reverse_right <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REVERSE_LEFT:  reverse_left  <= cfg_data;
        CFG_REVERSE_RIGHT: reverse_right <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Counters, snapshots and the per-item flags, all updated when an item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count       <= '0;
      right_count      <= '0;
      left_b_level     <= 1'b0;
      right_b_level    <= 1'b0;
      left_prev_count  <= '0;
      right_prev_count <= '0;
      prev_time        <= '0;
      dt_zero          <= 1'b0;
      is_velocity      <= 1'b0;
      fault            <= 1'b0;
    end else if (cmd.accept) begin
      is_velocity <= (operation == OP_VELOCITY);
      fault       <= (operation == OP_VELOCITY) && (dt_now == '0);
      case (operation)
        OP_EDGE_LEFT: begin
          left_count   <= left_edge;
          left_b_level <= pin_b;
        end
        OP_EDGE_RIGHT: begin
          right_count   <= right_edge;
          right_b_level <= pin_b;
        end
        OP_VELOCITY: begin
          dt_zero          <= (dt_now == '0);
          prev_time        <= now_ext;
          left_prev_count  <= left_count;
          right_prev_count <= right_count;
        end
        default: begin
        end
      endcase
    end
  end

  // Elapsed time for the lanes.
  always_ff @(posedge clk) begin
    if (vel_load) begin
      dt <= dt_now;
    end
  end

  qpv_lane #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_lane_left (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .load    (vel_load),
    .diff_in (left_count - left_prev_count),
    .dt      (dt),
    .dt_zero (dt_zero),
    .speed   (left_speed)
  );

  qpv_lane #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_lane_right (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .load    (vel_load),
    .diff_in (right_count - right_prev_count),
    .dt      (dt),
    .dt_zero (dt_zero),
    .speed   (right_speed)
  );

  // Result register, loaded once the item is finished.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pos_left   <= 32'($signed(left_count));
      pos_right  <= 32'($signed(right_count));
      vel_left   <= reported(left_speed, reverse_left);
      vel_right  <= reported(right_speed, reverse_right);
      time_fault <= fault;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/quadrature_position_velocity_top.sv =====
// Top level of the two-wheel quadrature position counter with velocity estimate.
//
// Input channel: in_valid/in_stall with operation, pin_a, pin_b and now_us.
// An edge item (left or right) updates that wheel's count from the sampled A
// and B levels; a velocity item takes a microsecond timestamp and computes
// both wheel speeds in Q16.16 rad/s. Every item yields exactly one result on
// the output channel (out_valid/out_stall) with both positions, both reported
// velocities and time_fault, set when a velocity item saw zero elapsed time.
// An edge item goes from acceptance through MAG to DONE; a velocity item
// runs MAG, MUL_LO, MUL_HI, DIV_INIT, DIV, SCALE, CLAMP and DONE, where DIV
// is the 32-step shift-subtract divider that each wheel's lane runs after
// the multiply by 1e6; zero elapsed time skips from MAG to CLAMP. One item
// is in flight at a time; no new item is taken until DONE loads a result.
// A finished result waits in the output register while out_stall is high,
// and the next item is accepted meanwhile; that item's result is held until
// the register drains. Reset clears counts, snapshots and speeds, sets
// reverse_left and clears reverse_right. Configuration writes (cfg_write,
// cfg_index, cfg_data) take effect at once and belong to idle periods.
`default_nettype none
module quadrature_position_velocity_top
  import qpv_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic        pin_a,
  input  wire logic        pin_b,
  input  wire logic [31:0] now_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      pos_left,
  output logic [31:0]      pos_right,
  output logic [31:0]      vel_left,
  output logic [31:0]      vel_right,
  output logic             time_fault
);

  cmd_t    cmd;
  status_t status;

  qpv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  qpv_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .operation  (operation),
    .pin_a      (pin_a),
    .pin_b      (pin_b),
    .now_us     (now_us),
    .pos_left   (pos_left),
    .pos_right  (pos_right),
    .vel_left   (vel_left),
    .vel_right  (vel_right),
    .time_fault (time_fault)
  );

endmodule
`default_nettype wire
